### src/wct_pkg.sv
`default_nettype none
package wct_pkg;
  localparam int HistoryDepthDefault = 16;
  localparam int SampleBitsDefault   = 16;
  localparam int ValW  = 16;
  localparam int SumW  = 33;
  localparam int WSumW = 40;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 8;
  localparam int DistW = 17;

  typedef enum logic [1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_WIN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DIV,
    ST_READ,
    ST_ROOT,
    ST_OUT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic div_start;
    logic commit;
    logic read_start;
    logic root_start;
    logic out_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic frame_end;
    logic div_done;
    logic root_done;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic        touch_found;
    logic [15:0] centroid_row;
    logic [15:0] centroid_col;
    logic        history_present;
    logic [16:0] motion_distance;
  } result_t;
endpackage
`default_nettype wire

### src/wct_cell_if.sv
`default_nettype none
interface wct_cell_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_value;
  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface
`default_nettype wire

### src/wct_result_if.sv
`default_nettype none
interface wct_result_if;
  logic        valid;
  logic        ready;
  logic        touch_found;
  logic [15:0] centroid_row;
  logic [15:0] centroid_col;
  logic        history_present;
  logic [16:0] motion_distance;
  modport source (output valid, output touch_found, output centroid_row,
                  output centroid_col, output history_present,
                  output motion_distance, input ready);
  modport sink (input valid, input touch_found, input centroid_row,
                input centroid_col, input history_present,
                input motion_distance, output ready);
endinterface
`default_nettype wire

### src/wct_ctrl.sv
`default_nettype none
module wct_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire wct_pkg::stat_t stat,
  output wct_pkg::cmd_t      cmd,
  output logic               in_ready
);
  import wct_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_ACCUM: begin
        in_ready = 1'b1;
        if (in_fire && stat.frame_end) begin
          state_nxt = ST_DIV;
          cmd.div_start = 1'b1;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.commit = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read_start = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (stat.root_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_ACCUM;
        end
      end
      default: state_nxt = ST_ACCUM;
    endcase
    cmd.root_start = (state_r == ST_READ);
  end
endmodule
`default_nettype wire

### src/wct_datapath.sv
`default_nettype none
module wct_datapath #(
  parameter int HISTORY_DEPTH = wct_pkg::HistoryDepthDefault,
  parameter int SAMPLE_BITS   = wct_pkg::SampleBitsDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_fire,
  input  wire logic [15:0]               in_value,
  input  wire logic                      cfg_we,
  input  wire logic [wct_pkg::CfgAddrW-1:0] cfg_idx,
  input  wire logic [wct_pkg::CfgDataW-1:0] cfg_data,
  input  wire wct_pkg::cmd_t             cmd,
  output wct_pkg::stat_t                 stat,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output wct_pkg::result_t               out_res
);
  import wct_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int NUMW = WSumW + 8;

  logic [7:0] rows_r, cols_r;
  logic [4:0] win_r;
  logic [7:0] row_r, col_r;
  logic [SumW-1:0]  sv_r;
  logic [WSumW-1:0] sr_r, sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 8'd8;
      cols_r <= 8'd8;
      win_r  <= 5'd2;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ROWS: rows_r <= cfg_data;
        CFG_COLS: cols_r <= cfg_data;
        CFG_WIN:  win_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [15:0] v;
  logic        last_col, last_row;
  assign v = 16'(in_value[SAMPLE_BITS-1:0]);
  assign last_col = ({1'b0, col_r} + 9'd1) >= {1'b0, cols_r};
  assign last_row = ({1'b0, row_r} + 9'd1) >= {1'b0, rows_r};
  assign stat.frame_end = last_col && last_row;

  logic [23:0] vr, vc;
  assign vr = v * row_r;
  assign vc = v * col_r;

  // Frame total latched at frame end; the accumulators restart.
  logic [SumW-1:0]  fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0; col_r <= '0;
      sv_r <= '0; sr_r <= '0; sc_r <= '0;
    end else if (in_fire) begin
      if (!last_col) begin
        col_r <= col_r + 8'd1;
      end else begin
        col_r <= '0;
        row_r <= last_row ? 8'd0 : row_r + 8'd1;
      end
      if (stat.frame_end) begin
        sv_r <= '0; sr_r <= '0; sc_r <= '0;
        fv_r <= sv_r + SumW'(v);
      end else begin
        sv_r <= sv_r + SumW'(v);
        sr_r <= sr_r + WSumW'(vr);
        sc_r <= sc_r + WSumW'(vc);
      end
    end
  end

  // Restoring divider, one quotient bit per cycle, row and column together.
  logic [NUMW-1:0] qr_r, qc_r;
  logic [SumW:0]   rr_r, rc_r;
  logic [5:0]      dcnt_r;
  logic            dbusy_r;
  logic [SumW:0]   rr_sh, rc_sh;
  assign rr_sh = {rr_r[SumW-1:0], qr_r[NUMW-1]};
  assign rc_sh = {rc_r[SumW-1:0], qc_r[NUMW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (cmd.div_start) begin
      // The last cell is still on the input, so its weight joins the sums here.
      dbusy_r <= 1'b1;
      dcnt_r  <= 6'(NUMW);
      qr_r <= {sr_r + WSumW'(vr), 8'd0};
      qc_r <= {sc_r + WSumW'(vc), 8'd0};
      rr_r <= '0; rc_r <= '0;
    end else if (dbusy_r) begin
      if (rr_sh >= {1'b0, fv_r}) begin
        rr_r <= rr_sh - {1'b0, fv_r};
        qr_r <= {qr_r[NUMW-2:0], 1'b1};
      end else begin
        rr_r <= rr_sh;
        qr_r <= {qr_r[NUMW-2:0], 1'b0};
      end
      if (rc_sh >= {1'b0, fv_r}) begin
        rc_r <= rc_sh - {1'b0, fv_r};
        qc_r <= {qc_r[NUMW-2:0], 1'b1};
      end else begin
        rc_r <= rc_sh;
        qc_r <= {qc_r[NUMW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 6'd1;
      if (dcnt_r == 6'd1) dbusy_r <= 1'b0;
    end
  end
  assign stat.div_done = dbusy_r && (dcnt_r == 6'd1) ? 1'b0 : (!dbusy_r);

  // Ring with valid bits; an unwritten entry reads as zero.
  logic [31:0]              ring_mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] ring_vld_r;
  logic [AW-1:0]            wslot_r;
  logic [FW-1:0]            fill_r;
  logic                     touch_r;
  logic                     nz;
  assign nz = (fv_r != '0);

  always_ff @(posedge clk) begin
    if (cmd.commit && nz) ring_mem[wslot_r] <= {qr_r[15:0], qc_r[15:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      wslot_r <= '0;
      fill_r <= '0;
    end else if (cmd.commit && nz) begin
      ring_vld_r[wslot_r] <= 1'b1;
      wslot_r <= (32'(wslot_r) == HISTORY_DEPTH - 1) ? '0 : wslot_r + AW'(1);
      if (32'(fill_r) < HISTORY_DEPTH) fill_r <= fill_r + FW'(1);
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.commit) touch_r <= nz;
  end

  function automatic logic [AW-1:0] back(input logic [AW-1:0] ws, input logic [FW-1:0] n);
    logic [FW:0] t;
    t = {1'b0, FW'(ws)} + (FW+1)'(HISTORY_DEPTH) - {1'b0, n};
    if (32'(t) >= HISTORY_DEPTH) t = t - (FW+1)'(HISTORY_DEPTH);
    return t[AW-1:0];
  endfunction

  logic [FW-1:0] nwin;
  logic [AW-1:0] sa, sb;
  always_comb begin
    nwin = (32'(win_r) > 32'(fill_r)) ? fill_r : FW'(win_r);
    if (nwin == '0) nwin = FW'(1);
    sa = back(wslot_r, FW'(1));
    sb = back(wslot_r, nwin);
  end

  logic [31:0] ea_r, eb_r;
  logic        va_r, vb_r;
  always_ff @(posedge clk) begin
    if (cmd.read_start) begin
      ea_r <= ring_mem[sa];
      eb_r <= ring_mem[sb];
      va_r <= ring_vld_r[sa];
      vb_r <= ring_vld_r[sb];
    end
  end
  logic [31:0] ea, eb;
  assign ea = va_r ? ea_r : 32'd0;
  assign eb = vb_r ? eb_r : 32'd0;

  // Square of displacement, then a bit-pair root, one step per cycle.
  logic [15:0] dr, dc;
  assign dr = (ea[31:16] >= eb[31:16]) ? ea[31:16] - eb[31:16] : eb[31:16] - ea[31:16];
  assign dc = (ea[15:0] >= eb[15:0]) ? ea[15:0] - eb[15:0] : eb[15:0] - ea[15:0];

  logic [1:0]  rph_r;
  logic [32:0] sq_r;
  logic [33:0] rv_r, rres_r, rbit_r;
  logic [4:0]  rcnt_r;
  logic        rbusy_r;
  logic [33:0] rtry;
  assign rtry = rres_r + rbit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rbusy_r <= 1'b0;
      rph_r <= '0;
      rcnt_r <= '0;
    end else if (cmd.root_start) begin
      rbusy_r <= 1'b1;
      rph_r <= 2'd1;
    end else if (rbusy_r && rph_r == 2'd1) begin
      sq_r <= 33'(dr * dr) + 33'(dc * dc);
      rph_r <= 2'd2;
    end else if (rbusy_r && rph_r == 2'd2) begin
      rv_r <= {1'b0, sq_r};
      rres_r <= '0;
      rbit_r <= 34'h1 << 32;
      rcnt_r <= 5'd17;
      rph_r <= 2'd3;
    end else if (rbusy_r) begin
      if (rv_r >= rtry) begin
        rv_r <= rv_r - rtry;
        rres_r <= (rres_r >> 1) + rbit_r;
      end else begin
        rres_r <= rres_r >> 1;
      end
      rbit_r <= rbit_r >> 2;
      rcnt_r <= rcnt_r - 5'd1;
      if (rcnt_r == 5'd1) rbusy_r <= 1'b0;
    end
  end
  assign stat.root_done = !rbusy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
      out_res.touch_found <= touch_r;
      out_res.centroid_row <= ea[31:16];
      out_res.centroid_col <= ea[15:0];
      out_res.history_present <= (fill_r != '0);
      out_res.motion_distance <= (fill_r < FW'(2)) ? '0 : rres_r[16:0];
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
  assign stat.out_busy = out_valid && !out_ready;
endmodule
`default_nettype wire

### src/weighted_centroid_tracker_top.sv
`default_nettype none
// Intensity-weighted centroid tracker. Cells stream in at one word per cycle
// in raster order; the last cell of a frame starts a post-frame pass (the
// 48-step divider for row and column together and the ring write, the ring
// read, the square and the 17-step square root, and the output load), during
// which no cell is taken. One result word per frame follows on the output
// register, which holds while the sink stalls; a stalled sink extends the pass
// until the register frees.
module weighted_centroid_tracker_top #(
  parameter int HISTORY_DEPTH = wct_pkg::HistoryDepthDefault,
  parameter int SAMPLE_BITS   = wct_pkg::SampleBitsDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  wct_cell_if.sink                           in_ch,
  wct_result_if.source                       out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [wct_pkg::CfgAddrW-1:0]  cfg_idx,
  input  wire logic [wct_pkg::CfgDataW-1:0]  cfg_data
);
  import wct_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  result_t res;
  logic    in_fire, rdy;

  assign in_ch.ready = rdy;
  assign in_fire = in_ch.valid && rdy;

  wct_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .stat(stat), .cmd(cmd), .in_ready(rdy)
  );

  wct_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_value(in_ch.cell_value),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_res(res)
  );

  assign out_ch.touch_found = res.touch_found;
  assign out_ch.centroid_row = res.centroid_row;
  assign out_ch.centroid_col = res.centroid_col;
  assign out_ch.history_present = res.history_present;
  assign out_ch.motion_distance = res.motion_distance;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !rdy) else $error("cell accepted during frame pass");
  a_touch_hist: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.touch_found |-> out_ch.history_present)
    else $error("touch without history");
  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_ch.valid && !out_ch.ready)) else $error("result overwritten");
endmodule
`default_nettype wire
